// ===== hw/rtl/scpf_pkg.sv =====
// Shared types and constants for the servo command packet framer.
package scpf_pkg;

    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned TORQ_W  = 11;

    localparam logic [1:0] KIND_TORQUE  = 2'd0;
    localparam logic [1:0] KIND_POSREAD = 2'd1;
    localparam logic [1:0] KIND_REVERSE = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1000;

    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] REG_TORQUE   = 8'd42;
    localparam logic [7:0] REG_POSITION = 8'd56;
    localparam logic [7:0] REG_REVERSE  = 8'd31;
    localparam logic [7:0] REVERSE_HIGH = 8'h08;
    localparam logic [7:0] LEN_WRITE    = 8'd9;
    localparam logic [7:0] LEN_READ     = 8'd4;
    localparam logic [7:0] INSTR_WRITE  = 8'd3;
    localparam logic [7:0] INSTR_READ   = 8'd2;
    localparam logic [7:0] READ_COUNT   = 8'd2;

    localparam logic [3:0] LAST_POS_READ  = 4'd7;
    localparam logic [3:0] LAST_POS_WRITE = 4'd12;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        servo;
        logic [TORQ_W-1:0] torque;
    } t_desc;

endpackage

// ===== hw/rtl/scpf_front.sv =====
// Request intake: limit register, torque saturation and sign-magnitude encoding.
module scpf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scpf_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_req_valid,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_servo_id,
    input  logic signed [15:0]          i_torque_command,
    output logic                        o_push,
    output scpf_pkg::t_desc             o_desc
);
    import scpf_pkg::*;

    logic [LIMIT_W-1:0] r_torque_limit;
    logic               neg;
    logic [16:0]        mag_full;
    logic [16:0]        mag_clamp;
    logic               sign_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_torque_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        neg      = i_torque_command[15];
        mag_full = neg ? (17'd0 - {i_torque_command[15], i_torque_command})
                       : {1'b0, i_torque_command};
        mag_clamp = (mag_full > {7'd0, r_torque_limit}) ? {7'd0, r_torque_limit} : mag_full;
        sign_bit  = neg && (mag_clamp != 17'd0);
    end

    assign o_push        = i_req_valid && (i_req_type != KIND_UNUSED);
    assign o_desc.kind   = i_req_type;
    assign o_desc.servo  = i_servo_id;
    assign o_desc.torque = {sign_bit, mag_clamp[LIMIT_W-1:0]};

endmodule

// ===== hw/rtl/scpf_queue.sv =====
// Two-entry request queue between intake and serializer.
module scpf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scpf_pkg::t_desc i_desc,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output scpf_pkg::t_desc o_desc
);
    import scpf_pkg::*;

    t_desc      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= ~r_wptr;
            if (do_pop)  r_rptr <= ~r_rptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/scpf_back.sv =====
// Packet serializer: byte sequencing, running checksum and output register.
module scpf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  scpf_pkg::t_desc i_desc,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);
    import scpf_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic [3:0] r_pos;
    logic [7:0] r_sum;

    logic       load;
    logic       is_read;
    logic       is_torque;
    logic [3:0] last_pos;
    logic       at_last;
    logic [7:0] n_byte;
    logic [7:0] n_sum;

    always_comb begin
        is_read   = (i_desc.kind == KIND_POSREAD);
        is_torque = (i_desc.kind == KIND_TORQUE);
        last_pos  = is_read ? LAST_POS_READ : LAST_POS_WRITE;
        at_last   = (r_pos == last_pos);
        load      = i_valid && (!r_valid || i_tready);

        case (r_pos) inside
            4'd0, 4'd1: n_byte = HDR_BYTE;
            4'd2:       n_byte = i_desc.servo;
            4'd3:       n_byte = is_read ? LEN_READ : LEN_WRITE;
            4'd4:       n_byte = is_read ? INSTR_READ : INSTR_WRITE;
            4'd5:       n_byte = is_read ? REG_POSITION : (is_torque ? REG_TORQUE : REG_REVERSE);
            4'd6:       n_byte = is_read ? READ_COUNT : 8'd0;
            4'd7:       n_byte = is_torque ? 8'd0 : REVERSE_HIGH;
            4'd8:       n_byte = is_torque ? i_desc.torque[7:0] : 8'd0;
            4'd9:       n_byte = is_torque ? {5'd0, i_desc.torque[TORQ_W-1:8]} : 8'd0;
            default:    n_byte = 8'd0;
        endcase
        if (at_last) n_byte = ~r_sum;

        n_sum = (r_pos == 4'd2) ? n_byte : (r_sum + n_byte);
    end

    assign o_pop    = load && at_last;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
            r_sum   <= 8'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= at_last ? 4'd0 : (r_pos + 4'd1);
            if (r_pos >= 4'd2 && !at_last) r_sum <= n_sum;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_byte;
            r_last <= at_last;
        end
    end

endmodule

// ===== hw/rtl/servo_command_packet_framer.sv =====
// Top level of the servo command packet framer.
//
//  channel   | direction | tdata                                  | tuser      | tlast
//  s_axis    | in        | [7:0] servo_id, [23:8] torque_command  | [1:0] type | -
//  m_axis    | out       | [7:0] tx_byte                          | -          | last_byte
//  cfg       | in        | i_cfg_wdata: torque_limit, on i_cfg_we | -          | -
//
// One packet byte leaves per cycle while m_axis_tready is high: a write packet is 13 bytes, a position read 8.
// That rate is set by the serializer emitting one byte per clock.
// A two-entry queue lets requests be taken while a packet is still going out.
// Reset clears the queue and serializer and restores torque_limit to 1000.
// m_axis_tready low holds the current byte; the queue then fills and s_axis_tready drops.
module servo_command_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] servo_id, [23:8] torque_command
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast    // last_byte
);
    import scpf_pkg::*;

    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  f_push;
    t_desc f_desc;
    t_desc q_desc;

    assign s_axis_tready = !q_full;

    scpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_valid      (s_axis_tvalid && !q_full),
        .i_req_type       (s_axis_tuser),
        .i_servo_id       (s_axis_tdata[7:0]),
        .i_torque_command (s_axis_tdata[23:8]),
        .o_push           (f_push),
        .o_desc           (f_desc)
    );

    scpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_desc  (f_desc),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_desc  (q_desc)
    );

    scpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_desc   (q_desc),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== dv/tb.sv =====
// Testbench for servo_command_packet_framer: directed table, random requests, byte scoreboard.
`timescale 1ns / 1ps

module tb;
    import scpf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int NUM_DIR       = 24;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 14;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tx_beat;

    typedef struct packed {
        logic              wr_limit;
        logic [9:0]        limit;
        logic [1:0]        kind;
        logic [7:0]        servo;
        logic [15:0]       torque;
        logic              typed;
        logic [TORQ_W-1:0] enc;
    } t_dir_row;

    // typed rows carry the sign-magnitude torque expected in bytes 8 and 9
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h00, 16'h0000, 1'b1, 11'h000},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'hFF, 16'h7FFF, 1'b1, 11'h3E8},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h01, 16'h8000, 1'b1, 11'h7E8},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h55, 16'h03E8, 1'b1, 11'h3E8},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'hAA, 16'hFC18, 1'b1, 11'h7E8},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h03, 16'h03E9, 1'b1, 11'h3E8},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h04, 16'hFFFF, 1'b1, 11'h401},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h05, 16'h0001, 1'b1, 11'h001},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h06, 16'h03E7, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h80, 16'hFC19, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_POSREAD, 8'h00, 16'h0000, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_POSREAD, 8'hFF, 16'hFFFF, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_REVERSE, 8'h00, 16'h0000, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_REVERSE, 8'hFF, 16'h7FFF, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_UNUSED,  8'h07, 16'h007B, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_UNUSED,  8'hFF, 16'hFFFF, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h7F, 16'h0200, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_POSREAD, 8'h12, 16'h8000, 1'b0, 11'h000},
        '{1'b0, 10'd0,    KIND_REVERSE, 8'h34, 16'h1234, 1'b0, 11'h000},
        // zero limit: everything collapses to 0, no negative zero
        '{1'b1, 10'd0,    KIND_TORQUE,  8'h21, 16'hFFFB, 1'b1, 11'h000},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h22, 16'h8000, 1'b1, 11'h000},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h23, 16'h7FFF, 1'b1, 11'h000},
        '{1'b1, 10'd1023, KIND_TORQUE,  8'h24, 16'h8000, 1'b1, 11'h7FF},
        '{1'b0, 10'd0,    KIND_TORQUE,  8'h25, 16'h7FFF, 1'b1, 11'h3FF}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [9:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [7:0] servo_id, [23:8] torque_command
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] tx_byte
    logic        m_axis_tlast;         // last_byte

    logic [9:0]        torque_limit = LIMIT_RESET;
    logic              fix_enc      = 1'b0;
    logic [TORQ_W-1:0] fix_enc_val  = '0;
    int                send_idle_pct;
    int                recv_idle_pct;

    t_tx_beat expected_beats [$];
    int       err_count;
    int       beats_checked;
    int       ignored_reqs;
    int       packets [3];
    int       cycles;

    servo_command_packet_framer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TORQ_W-1:0] clamp_sign_mag(logic signed [15:0] cmd,
                                                         logic [9:0] lim);
        int t;
        int l;
        t = cmd;
        l = lim;
        if (t > l) t = l;
        if (t < -l) t = -l;
        if (t < 0) return {1'b1, 10'(-t)};
        return {1'b0, 10'(t)};
    endfunction

    function automatic void frame_packet(logic [1:0] kind, logic [7:0] servo,
                                         logic [TORQ_W-1:0] enc);
        logic [7:0] pkt [13];
        int         len;
        logic [7:0] sum;
        foreach (pkt[i]) pkt[i] = 8'h00;
        pkt[0] = HDR_BYTE;
        pkt[1] = HDR_BYTE;
        pkt[2] = servo;
        if (kind == KIND_POSREAD) begin
            len    = 8;
            pkt[3] = LEN_READ;
            pkt[4] = INSTR_READ;
            pkt[5] = REG_POSITION;
            pkt[6] = READ_COUNT;
        end else begin
            len    = 13;
            pkt[3] = LEN_WRITE;
            pkt[4] = INSTR_WRITE;
            if (kind == KIND_TORQUE) begin
                pkt[5] = REG_TORQUE;
                pkt[8] = enc[7:0];
                pkt[9] = {5'b0, enc[10:8]};
            end else begin
                pkt[5] = REG_REVERSE;
                pkt[7] = REVERSE_HIGH;
            end
        end
        sum = 8'h00;
        for (int i = 2; i < len - 1; i++) sum = sum + pkt[i];
        pkt[len-1] = ~sum;
        for (int i = 0; i < len; i++) expected_beats.push_back({pkt[i], 1'(i == len - 1)});
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("%t %s", $realtime, msg);
    endfunction

    function automatic logic [15:0] pick_torque(logic [9:0] lim);
        int v;
        int l;
        l = lim;
        case ($urandom_range(4))
            0: v = int'($urandom_range(65535)) - 32768;
            1: begin
                v = l + int'($urandom_range(4)) - 2;
                if ($urandom_range(1)) v = -v;
            end
            2: v = int'($urandom_range(6)) - 3;
            3: v = $urandom_range(1) ? 32767 : -32768;
            default: v = int'($urandom_range(2 * l)) - l;
        endcase
        return v[15:0];
    endfunction

    // prediction on input transactions, comparison on output transactions
    always @(posedge i_clk) begin : scoreboard
        logic [TORQ_W-1:0] enc;
        t_tx_beat          want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == KIND_UNUSED) begin
                    ignored_reqs++;
                end else begin
                    enc = fix_enc ? fix_enc_val
                                  : clamp_sign_mag(s_axis_tdata[23:8], torque_limit);
                    frame_packet(s_axis_tuser, s_axis_tdata[7:0], enc);
                    packets[s_axis_tuser]++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h last %0b",
                                         m_axis_tdata, m_axis_tlast));
                end else begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
                        note_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                             beats_checked, want.data, want.last,
                                             m_axis_tdata, m_axis_tlast));
                end
                beats_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] kind, logic [7:0] servo, logic [15:0] torque,
                                logic typed, logic [TORQ_W-1:0] enc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {torque, servo};
        fix_enc       <= typed;
        fix_enc_val   <= enc;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain(bit settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        fix_enc       <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [9:0] lim);
        drain(1'b1);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        torque_limit = lim;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_profile(int pass_no);
        case (pass_no)
            0: begin send_idle_pct = 14; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    initial begin : stimulus
        logic [9:0] phase_limit [NUM_PHASES];
        logic [1:0] kind;
        int         sent;
        int         r;
        set_profile(0);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].wr_limit) write_limit(DIR_ROWS[i].limit);
            send_request(DIR_ROWS[i].kind, DIR_ROWS[i].servo, DIR_ROWS[i].torque,
                         DIR_ROWS[i].typed, DIR_ROWS[i].enc);
        end

        phase_limit = '{10'($urandom_range(1023)), 10'd0, 10'd1023,
                        10'($urandom_range(1023)), 10'd1, 10'($urandom_range(1023))};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(phase_limit[p]);
            set_profile(p / 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(14) == 0) drain(1'b0);
                r = $urandom_range(19);
                if (r == 0) kind = KIND_UNUSED;
                else if (r < 11) kind = KIND_TORQUE;
                else if (r < 15) kind = KIND_POSREAD;
                else kind = KIND_REVERSE;
                send_request(kind, 8'($urandom_range(255)), pick_torque(torque_limit),
                             1'b0, '0);
                if (kind != KIND_UNUSED) sent++;
            end
        end

        drain(1'b1);
        $display("tb: %0d torque, %0d position read, %0d reverse packets, %0d ignored requests",
                 packets[KIND_TORQUE], packets[KIND_POSREAD], packets[KIND_REVERSE],
                 ignored_reqs);
        $display("tb: %0d bytes compared over %0d limit settings, %0d mismatches",
                 beats_checked, NUM_PHASES + 3, err_count);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/scpf_pkg.sv
hw/rtl/scpf_front.sv
hw/rtl/scpf_queue.sv
hw/rtl/scpf_back.sv
hw/rtl/servo_command_packet_framer.sv
dv/tb.sv
